>>> rtl/rbdp_pkg.sv
// Shared constants, codes and types of the ring buffer drain planner.
package rbdp_pkg;

	localparam int ADDR_W = 32;

	// A ring entry is one 32-bit word, so a word index becomes a byte offset by a shift of two.
	localparam int WORD_SHIFT = 2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 1'd1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CFG_ZERO = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	typedef struct packed {
		logic       two_chunks;
		logic       head_write;
		logic       block_update;
		logic [1:0] status;
	} plan_flags_t;

endpackage

>>> rtl/rbdp_if.sv
// Request and result channel interfaces of the ring buffer drain planner.
interface rbdp_req_if #(
	parameter int IW = 16
);
	logic          valid;
	logic          ready;
	logic [IW-1:0] ring_head;
	logic [IW-1:0] ring_tail;
	logic [IW-1:0] words_wanted;
	logic          sync_mode;

	modport source (output valid, ring_head, ring_tail, words_wanted, sync_mode, input ready);
	modport sink (input valid, ring_head, ring_tail, words_wanted, sync_mode, output ready);
endinterface

interface rbdp_res_if #(
	parameter int IW = 16
);
	logic                        valid;
	logic                        ready;
	logic [rbdp_pkg::ADDR_W-1:0] chunk_address;
	logic [IW-1:0]               chunk_words;
	logic                        is_last;
	logic [IW-1:0]               new_head;
	logic [IW-1:0]               total_words;
	logic [IW-1:0]               words_pending;
	logic                        head_write;
	logic                        block_update;
	logic [1:0]                  status;

	modport source (output valid, chunk_address, chunk_words, is_last, new_head, total_words,
		words_pending, head_write, block_update, status, input ready);
	modport sink (input valid, chunk_address, chunk_words, is_last, new_head, total_words,
		words_pending, head_write, block_update, status, output ready);
endinterface

>>> rtl/rbdp_emit.sv
// Output stage: holds one planned request and sends its one or two chunk results.
module rbdp_emit #(
	parameter int IW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rbdp_pkg::plan_flags_t       in_flags,
	input  logic [rbdp_pkg::ADDR_W-1:0] in_addr_a,
	input  logic [IW-1:0]               in_words_a,
	input  logic [rbdp_pkg::ADDR_W-1:0] in_addr_b,
	input  logic [IW-1:0]               in_words_b,
	input  logic [IW-1:0]               in_new_head,
	input  logic [IW-1:0]               in_total,
	input  logic [IW-1:0]               in_pending,
	rbdp_res_if.source                  res
);

	logic                        v_s3;
	logic                        phase_q;
	rbdp_pkg::plan_flags_t       flags_s3;
	logic [rbdp_pkg::ADDR_W-1:0] addr_a_s3;
	logic [IW-1:0]               words_a_s3;
	logic [rbdp_pkg::ADDR_W-1:0] addr_b_s3;
	logic [IW-1:0]               words_b_s3;
	logic [IW-1:0]               new_head_s3;
	logic [IW-1:0]               total_s3;
	logic [IW-1:0]               pending_s3;
	logic                        last;

	assign last     = !flags_s3.two_chunks || phase_q;
	assign in_ready = !v_s3 || (res.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			phase_q <= 1'b0;
		end else if (in_ready) begin
			v_s3    <= in_valid;
			phase_q <= 1'b0;
		end else if (res.ready && !last) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			flags_s3    <= in_flags;
			addr_a_s3   <= in_addr_a;
			words_a_s3  <= in_words_a;
			addr_b_s3   <= in_addr_b;
			words_b_s3  <= in_words_b;
			new_head_s3 <= in_new_head;
			total_s3    <= in_total;
			pending_s3  <= in_pending;
		end
	end

	// The summary of the request rides only on its last result.
	assign res.valid         = v_s3;
	assign res.is_last       = last;
	assign res.chunk_address = phase_q ? addr_b_s3 : addr_a_s3;
	assign res.chunk_words   = phase_q ? words_b_s3 : words_a_s3;
	assign res.new_head      = last ? new_head_s3 : '0;
	assign res.total_words   = last ? total_s3 : '0;
	assign res.words_pending = last ? pending_s3 : '0;
	assign res.head_write    = last && flags_s3.head_write;
	assign res.block_update  = last && flags_s3.block_update;
	assign res.status        = last ? flags_s3.status : rbdp_pkg::STATUS_OK;

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.is_last) |=> (res.valid && res.is_last))
		else $error("second chunk of a split request did not follow");

	a_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (v_s3 && flags_s3.two_chunks))
		else $error("second phase without a held split request");

	a_write_has_words: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.head_write) |-> (res.total_words != '0))
		else $error("head write reported with no words taken");

	a_update_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.block_update) |-> res.head_write)
		else $error("block update without head write");

	a_error_reads_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != rbdp_pkg::STATUS_OK) |->
		(res.is_last && res.chunk_words == '0 && !res.head_write))
		else $error("error status with a chunk or head write");

endmodule

>>> rtl/ring_buffer_drain_planner_top.sv
// Ring buffer drain planner: config registers, two planning stages and the output stage.
// A request accepted into stage 1 passes through stage 2 and the output stage before its first result.
// Up to one request per cycle while the result port takes results; a request split at the ring's
// wrap point sends two results over the single result port and holds the output stage for both.
// Reset clears all pipeline valid bits and sets ring_base and ring_size to zero.
module ring_buffer_drain_planner_top #(
	parameter int INDEX_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rbdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbdp_pkg::ADDR_W-1:0]    cfg_wdata,
	rbdp_req_if.sink                       req,
	rbdp_res_if.source                     res
);

	localparam int IW = INDEX_BITS;

	logic [rbdp_pkg::ADDR_W-1:0] ring_base_q;
	logic [IW-1:0]               ring_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_base_q <= '0;
			ring_size_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbdp_pkg::CFG_RING_BASE: ring_base_q <= cfg_wdata;
				rbdp_pkg::CFG_RING_SIZE: ring_size_q <= cfg_wdata[IW-1:0];
				default: ;
			endcase
		end
	end

	logic en_s1, en_s2, emit_ready;
	logic v_s1, v_s2;

	assign en_s2     = !v_s2 || emit_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// Stage 1: range checks, index folding and the words available in the ring.
	logic          bad_range, cfg_zero;
	logic [1:0]    status_in;
	logic [IW-1:0] h_in, t_in, avail1_in, avail_all_in;
	logic          h_lt_t_in, h_eq_t_in;

	always_comb begin
		bad_range = (req.ring_head > ring_size_q) || (req.ring_tail > ring_size_q);
		cfg_zero  = (ring_size_q == '0) || (ring_base_q == '0);
		if (bad_range) begin
			status_in = rbdp_pkg::STATUS_RANGE;
		end else if (cfg_zero) begin
			status_in = rbdp_pkg::STATUS_CFG_ZERO;
		end else begin
			status_in = rbdp_pkg::STATUS_OK;
		end
		h_in      = (req.ring_head == ring_size_q) ? '0 : req.ring_head;
		t_in      = (req.ring_tail == ring_size_q) ? '0 : req.ring_tail;
		h_lt_t_in = h_in < t_in;
		h_eq_t_in = h_in == t_in;
		avail1_in = h_lt_t_in ? (t_in - h_in) : (ring_size_q - h_in);
		if (h_eq_t_in) begin
			avail_all_in = '0;
		end else if (h_lt_t_in) begin
			avail_all_in = t_in - h_in;
		end else begin
			avail_all_in = ring_size_q - h_in + t_in;
		end
	end

	logic [1:0]    status_s1;
	logic [IW-1:0] raw_head_s1, h_s1, t_s1, wanted_s1, avail_all_s1, avail1_s1;
	logic          sync_s1, h_lt_t_s1, h_eq_t_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= req.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			status_s1    <= status_in;
			raw_head_s1  <= req.ring_head;
			h_s1         <= h_in;
			t_s1         <= t_in;
			wanted_s1    <= req.words_wanted;
			sync_s1      <= req.sync_mode;
			avail_all_s1 <= avail_all_in;
			avail1_s1    <= avail1_in;
			h_lt_t_s1    <= h_lt_t_in;
			h_eq_t_s1    <= h_eq_t_in;
		end
	end

	// Stage 2: first chunk, its start address and where the head lands after it.
	logic                        active_c, second_c;
	logic [IW-1:0]               seg1_c, left_c, h1_c, pend1_c;
	logic [IW:0]                 h1_sum;
	logic [IW+rbdp_pkg::WORD_SHIFT-1:0] h_bytes;
	logic [rbdp_pkg::ADDR_W-1:0] addr1_c;

	always_comb begin
		active_c = (status_s1 == rbdp_pkg::STATUS_OK) && !h_eq_t_s1 && (wanted_s1 != '0);
		if (!active_c) begin
			seg1_c = '0;
		end else if (wanted_s1 < avail1_s1) begin
			seg1_c = wanted_s1;
		end else begin
			seg1_c = avail1_s1;
		end
		left_c  = wanted_s1 - seg1_c;
		h1_sum  = {1'b0, h_s1} + {1'b0, seg1_c};
		h1_c    = (h1_sum >= {1'b0, ring_size_q}) ? '0 : h1_sum[IW-1:0];
		h_bytes = {h_s1, {rbdp_pkg::WORD_SHIFT{1'b0}}};
		addr1_c = ring_base_q + rbdp_pkg::ADDR_W'(h_bytes);
		pend1_c = avail_all_s1 - seg1_c;
		// Only a drain that runs off the end of the ring continues from index zero.
		second_c = active_c && !h_lt_t_s1 && (left_c != '0) && (t_s1 != '0);
	end

	logic [1:0]                  status_s2;
	logic [IW-1:0]               raw_head_s2, seg1_s2, left_s2, h1_s2, t_s2, pend1_s2;
	logic                        sync_s2, active_s2, second_s2;
	logic [rbdp_pkg::ADDR_W-1:0] addr1_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			status_s2   <= status_s1;
			raw_head_s2 <= raw_head_s1;
			sync_s2     <= sync_s1;
			active_s2   <= active_c;
			second_s2   <= second_c;
			addr1_s2    <= addr1_c;
			seg1_s2     <= seg1_c;
			left_s2     <= left_c;
			h1_s2       <= h1_c;
			t_s2        <= t_s1;
			pend1_s2    <= pend1_c;
		end
	end

	// Stage 3 inputs: second chunk and the request summary.
	logic [IW-1:0]               seg2_c, new_head_c, total_c, pending_c;
	rbdp_pkg::plan_flags_t       flags_c;
	logic [rbdp_pkg::ADDR_W-1:0] addr_a_c;

	always_comb begin
		if (!second_s2) begin
			seg2_c = '0;
		end else if (left_s2 < t_s2) begin
			seg2_c = left_s2;
		end else begin
			seg2_c = t_s2;
		end
		if (!active_s2) begin
			new_head_c = raw_head_s2;
		end else if (second_s2) begin
			new_head_c = seg2_c;
		end else begin
			new_head_c = h1_s2;
		end
		total_c   = seg1_s2 + seg2_c;
		pending_c = (status_s2 == rbdp_pkg::STATUS_OK) ? (pend1_s2 - seg2_c) : '0;
		addr_a_c  = active_s2 ? addr1_s2 : '0;
		flags_c.two_chunks   = second_s2;
		flags_c.head_write   = active_s2;
		flags_c.block_update = active_s2 && sync_s2;
		flags_c.status       = status_s2;
	end

	rbdp_emit #(
		.IW(IW)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s2),
		.in_ready   (emit_ready),
		.in_flags   (flags_c),
		.in_addr_a  (addr_a_c),
		.in_words_a (seg1_s2),
		.in_addr_b  (ring_base_q),
		.in_words_b (seg2_c),
		.in_new_head(new_head_c),
		.in_total   (total_c),
		.in_pending (pending_c),
		.res        (res)
	);

endmodule

>>> tb/tb_ring_buffer_drain_planner_top.sv
// Self-checking testbench of the ring buffer drain planner, with its own plan predictor.
module tb_ring_buffer_drain_planner_top;

	localparam int IW = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [IW-1:0] head;
		logic [IW-1:0] tail;
		logic [IW-1:0] wanted;
		logic          sync;
	} drain_req_t;

	typedef struct packed {
		logic [rbdp_pkg::ADDR_W-1:0] chunk_address;
		logic [IW-1:0]               chunk_words;
		logic                        is_last;
		logic [IW-1:0]               new_head;
		logic [IW-1:0]               total_words;
		logic [IW-1:0]               words_pending;
		logic                        head_write;
		logic                        block_update;
		logic [1:0]                  status;
	} plan_res_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rbdp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rbdp_pkg::ADDR_W-1:0]    cfg_wdata;

	rbdp_req_if #(.IW(IW)) req_ch ();
	rbdp_res_if #(.IW(IW)) res_ch ();

	ring_buffer_drain_planner_top #(.INDEX_BITS(IW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	// Copy of the ring registers as last written.
	logic [rbdp_pkg::ADDR_W-1:0] ring_base_q;
	logic [IW-1:0]               ring_size_q;

	drain_req_t pending_reqs[$];
	plan_res_t  plans_due[$];
	drain_req_t in_flight;
	drain_req_t next_req;
	plan_res_t  got;
	plan_res_t  want;
	bit         no_idle;
	int         mismatches;
	int         cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void plan_drain(drain_req_t r);
		int unsigned h;
		int unsigned t;
		int unsigned seg;
		int unsigned left;
		int unsigned taken;
		int unsigned pend;
		int unsigned size;
		int          n;
		logic [1:0]  st;
		plan_res_t   chunks[2];

		size = 32'(ring_size_q);
		st = rbdp_pkg::STATUS_OK;
		if (r.head > ring_size_q || r.tail > ring_size_q)
			st = rbdp_pkg::STATUS_RANGE;
		else if (ring_size_q == 0 || ring_base_q == 0)
			st = rbdp_pkg::STATUS_CFG_ZERO;
		if (st != rbdp_pkg::STATUS_OK) begin
			chunks[0] = '0;
			chunks[0].is_last = 1'b1;
			chunks[0].new_head = r.head;
			chunks[0].status = st;
			plans_due.push_back(chunks[0]);
			return;
		end

		// An index equal to the ring size is the same slot as index zero.
		h = (r.head == ring_size_q) ? 0 : 32'(r.head);
		t = (r.tail == ring_size_q) ? 0 : 32'(r.tail);
		left = 32'(r.wanted);
		taken = 0;
		n = 0;
		while (n < 2 && h != t && left > 0) begin
			seg = (h < t) ? t - h : size - h;
			if (seg > left)
				seg = left;
			chunks[n] = '0;
			chunks[n].chunk_address = ring_base_q +
				rbdp_pkg::ADDR_W'(h << rbdp_pkg::WORD_SHIFT);
			chunks[n].chunk_words = IW'(seg);
			n++;
			taken += seg;
			left -= seg;
			h += seg;
			if (h >= size)
				h = 0;
		end
		pend = (h == t) ? 0 : (h < t) ? t - h : size - h + t;

		if (n == 0) begin
			chunks[0] = '0;
			n = 1;
		end
		chunks[n-1].is_last = 1'b1;
		chunks[n-1].new_head = (taken > 0) ? IW'(h) : r.head;
		chunks[n-1].total_words = IW'(taken);
		chunks[n-1].words_pending = IW'(pend);
		chunks[n-1].head_write = (taken > 0);
		chunks[n-1].block_update = (taken > 0) && r.sync;
		for (int i = 0; i < n; i++)
			plans_due.push_back(chunks[i]);
	endfunction

	task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				plan_drain(in_flight);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 32)) begin
					next_req = pending_reqs.pop_front();
					in_flight = next_req;
					req_ch.valid <= 1'b1;
					req_ch.ring_head <= next_req.head;
					req_ch.ring_tail <= next_req.tail;
					req_ch.words_wanted <= next_req.wanted;
					req_ch.sync_mode <= next_req.sync;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= no_idle || ($urandom_range(99) >= 32);
			if (res_ch.valid && res_ch.ready) begin
				got.chunk_address = res_ch.chunk_address;
				got.chunk_words = res_ch.chunk_words;
				got.is_last = res_ch.is_last;
				got.new_head = res_ch.new_head;
				got.total_words = res_ch.total_words;
				got.words_pending = res_ch.words_pending;
				got.head_write = res_ch.head_write;
				got.block_update = res_ch.block_update;
				got.status = res_ch.status;
				if (plans_due.size() == 0) begin
					$error("result with no request waiting for it: %p", got);
					mismatches++;
				end else begin
					want = plans_due.pop_front();
					compare_field("chunk_address", want.chunk_address, got.chunk_address);
					compare_field("chunk_words", 32'(want.chunk_words),
						32'(got.chunk_words));
					compare_field("is_last", 32'(want.is_last), 32'(got.is_last));
					compare_field("new_head", 32'(want.new_head), 32'(got.new_head));
					compare_field("total_words", 32'(want.total_words),
						32'(got.total_words));
					compare_field("words_pending", 32'(want.words_pending),
						32'(got.words_pending));
					compare_field("head_write", 32'(want.head_write),
						32'(got.head_write));
					compare_field("block_update", 32'(want.block_update),
						32'(got.block_update));
					compare_field("status", 32'(want.status), 32'(got.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic add_req(int head, int tail, int wanted, bit sync);
		drain_req_t r;

		r.head = IW'(head);
		r.tail = IW'(tail);
		r.wanted = IW'(wanted);
		r.sync = sync;
		pending_reqs.push_back(r);
	endtask

	task automatic set_ring(logic [rbdp_pkg::ADDR_W-1:0] base, int size);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rbdp_pkg::CFG_RING_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= rbdp_pkg::CFG_RING_SIZE;
		// Bits above the size register are junk that the block must drop.
		cfg_wdata <= {16'($urandom), IW'(size)};
		@(posedge clk);
		cfg_we <= 1'b0;
		ring_base_q = base;
		ring_size_q = IW'(size);
	endtask

	// Checked mid-cycle so that the driver's updates of this cycle are already visible.
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_ch.valid || plans_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly legal head and tail positions, with a share of indexes past the ring size.
	task automatic add_random(int count);
		int head;
		int tail;
		int wanted;
		int roll;

		for (int i = 0; i < count; i++) begin
			head = $urandom_range(ring_size_q, 0);
			tail = $urandom_range(ring_size_q, 0);
			roll = $urandom_range(99);
			if (roll < 10 && ring_size_q != 16'hFFFF) begin
				if (roll < 5)
					head = $urandom_range(65535, int'(ring_size_q) + 1);
				else
					tail = $urandom_range(65535, int'(ring_size_q) + 1);
				if (roll % 2 == 0)
					head = $urandom_range(65535);
			end else if (roll < 16) begin
				tail = head;
			end else if (roll < 22) begin
				head = int'(ring_size_q);
			end
			roll = $urandom_range(99);
			if (roll < 5)
				wanted = 0;
			else if (roll < 35)
				wanted = $urandom_range(8, 1);
			else if (roll < 65)
				wanted = $urandom_range(65535);
			else
				wanted = $urandom_range(ring_size_q, 1);
			add_req(head, tail, wanted, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rbdp_pkg::CFG_RING_BASE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.ring_head = '0;
		req_ch.ring_tail = '0;
		req_ch.words_wanted = '0;
		req_ch.sync_mode = 1'b0;
		res_ch.ready = 1'b0;
		ring_base_q = '0;
		ring_size_q = '0;
		no_idle = 1'b0;
		mismatches = 0;
		cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Registers straight out of reset: size and base are both zero.
		add_req(0, 0, 5, 1);
		add_req(1, 0, 5, 0);
		add_req(0, 65535, 65535, 1);
		add_random(20);
		wait_idle();

		set_ring(32'h1000_0000, 16);
		add_req(0, 5, 100, 1);
		add_req(12, 4, 100, 0);
		add_req(12, 4, 3, 1);
		add_req(12, 4, 4, 1);
		add_req(12, 4, 6, 0);
		add_req(3, 9, 0, 1);
		add_req(7, 7, 20, 1);
		add_req(16, 3, 10, 1);
		add_req(10, 16, 10, 0);
		add_req(16, 16, 10, 1);
		add_req(17, 3, 10, 1);
		add_req(3, 17, 10, 1);
		add_req(65535, 65535, 10, 0);
		add_req(0, 15, 65535, 1);
		add_req(15, 14, 65535, 1);
		add_random(150);
		wait_idle();

		// Zero base: the range check still takes precedence.
		set_ring(32'h0, 16);
		add_req(20, 3, 4, 1);
		add_random(40);
		wait_idle();

		set_ring(32'hFFFF_FFFF, 65535);
		add_req(65535, 65535, 65535, 1);
		add_req(65534, 0, 65535, 1);
		add_req(1, 0, 65535, 1);
		add_req(40000, 32768, 65535, 0);
		add_random(150);
		wait_idle();

		set_ring($urandom_range(32'hFFFF_FFFF, 1), 1);
		add_random(80);
		wait_idle();

		set_ring($urandom_range(32'hFFFF_FFFF, 1), 0);
		add_random(30);
		wait_idle();

		no_idle = 1'b1;
		set_ring($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(64, 2));
		add_random(300);
		wait_idle();
		no_idle = 1'b0;

		for (int p = 0; p < 3; p++) begin
			set_ring($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(65535, 1));
			add_random(100);
			wait_idle();
		end

		set_ring($urandom, $urandom_range(200, 4));
		add_random(100);
		wait_idle();

		if (mismatches == 0 && plans_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/rbdp_pkg.sv
rtl/rbdp_if.sv
rtl/rbdp_emit.sv
rtl/ring_buffer_drain_planner_top.sv
tb/tb_ring_buffer_drain_planner_top.sv
